[rtl/core/rsbw_pkg.sv]
// ----------------------------------------------------------------------------
// Radial smoothstep brush weight: shared package
// Request and response payload types, register map and pipeline constants.
// ----------------------------------------------------------------------------
package rsbw_pkg;

   // Default grid geometry.
   localparam int CELLS_PER_SIDE_DEF = 64;
   localparam int CELL_SIZE_DEF      = 256;

   // Register port geometry.
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // Fixed-point constants (Q1.16 one, and three in Q2.16).
   localparam logic [16:0] Q16_ONE   = 17'h10000;
   localparam logic [17:0] Q16_THREE = 18'h30000;

   // Digit-serial pipeline depths: one root bit and one quotient bit a stage.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 17;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_CENTER_X       = 2'd0,
      REG_CENTER_Z       = 2'd1,
      REG_BRUSH_RADIUS   = 2'd2,
      REG_BRUSH_STRENGTH = 2'd3
   } reg_idx_type;

   // Request payload: one grid cell.
   typedef struct packed {
      logic signed [15:0] chunk_x;
      logic signed [15:0] chunk_z;
      logic [5:0]         cell_col;
      logic [5:0]         cell_row;
   } rsbw_req_type;

   // Response payload: brush weight of that cell.
   typedef struct packed {
      logic        hit;
      logic [11:0] cell_index;
      logic [15:0] weight;
   } rsbw_rsp_type;

   // Side information that travels with each request down the pipeline.
   typedef struct packed {
      logic        ok;
      logic [11:0] idx;
   } rsbw_tag_type;

endpackage

[rtl/core/radial_smoothstep_brush_weight.sv]
// ----------------------------------------------------------------------------
// Radial smoothstep brush weight
// Returns the circular smoothstep falloff of a brush for one terrain cell.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the req_ channel names one grid cell by chunk coordinates
// and cell column and row. The block returns one response per request on the
// rsp_ channel, in order: the cell index, the Q8.8 weight and a hit flag.
// The brush centre, radius and strength are set over the APB-style register
// port; the user must do so only while no request is in flight, as the block does not check it.
// The pipeline holds 58 register stages: five front stages, 32 square-root
// stages (one root bit each), 17 divider stages (one quotient bit each), three
// polynomial stages and the output register. Throughput is one request a cycle;
// the pipeline is fully occupied when the receiver always takes responses.
// When the receiver stalls, the whole pipeline holds and req_ready falls
// until the waiting response is taken; nothing is lost or repeated.
// Reset empties the pipeline and clears the configuration registers to zero,
// which disables the brush until radius and strength are written.
// ----------------------------------------------------------------------------
module radial_smoothstep_brush_weight
   import rsbw_pkg::*;
#(
   parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF,
   parameter int CELL_SIZE      = CELL_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rsbw_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsbw_rsp_type      rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   // Position widths follow from the grid geometry.
   localparam int SPAN_W = $clog2((CELLS_PER_SIDE + 64) * CELL_SIZE);
   localparam int POS_W  = SPAN_W + 17;
   localparam int DIFF_W = ((POS_W > 32) ? POS_W : 32) + 1;
   localparam int IDXP_W = 13 + $clog2(CELLS_PER_SIDE);
   localparam logic [POS_W-1:0] SPAN_C = POS_W'((CELLS_PER_SIDE - 1) * CELL_SIZE);
   localparam logic [POS_W-1:0] CS_C   = POS_W'(CELL_SIZE);
   localparam logic [IDXP_W-1:0] CPS_C = IDXP_W'(CELLS_PER_SIDE);

   // Configuration registers.
   logic signed [31:0] center_x_ff;
   logic signed [31:0] center_z_ff;
   logic [15:0]        radius_ff;
   logic [15:0]        strength_ff;
   reg_idx_type        reg_sel;

   assign reg_sel = reg_idx_type'(paddr[3:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= '0;
         strength_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            REG_CENTER_X:       center_x_ff <= pwdata;
            REG_CENTER_Z:       center_z_ff <= pwdata;
            REG_BRUSH_RADIUS:   radius_ff   <= pwdata[15:0];
            REG_BRUSH_STRENGTH: strength_ff <= pwdata[15:0];
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_sel)
         REG_CENTER_X:       prdata = center_x_ff;
         REG_CENTER_Z:       prdata = center_z_ff;
         REG_BRUSH_RADIUS:   prdata = {16'd0, radius_ff};
         REG_BRUSH_STRENGTH: prdata = {16'd0, strength_ff};
      endcase
   end

   // The whole pipeline advances together unless the output is held.
   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: capture the request.
   logic         s1_vld_ff;
   rsbw_req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: world position of the cell and its index.
   logic                    s2_vld_ff;
   rsbw_tag_type            s2_tag_ff;
   logic signed [POS_W-1:0] s2_wx_ff, s2_wz_ff;
   logic signed [POS_W-1:0] s2_wx_in, s2_wz_in;
   logic [IDXP_W-1:0]       s2_idx_full;

   always_comb begin
      s2_wx_in = POS_W'(s1_req_ff.chunk_x) * SPAN_C + POS_W'(s1_req_ff.cell_col) * CS_C;
      s2_wz_in = POS_W'(s1_req_ff.chunk_z) * SPAN_C + POS_W'(s1_req_ff.cell_row) * CS_C;
      s2_idx_full = IDXP_W'(s1_req_ff.cell_row) * CPS_C + IDXP_W'(s1_req_ff.cell_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_wx_ff      <= s2_wx_in;
         s2_wz_ff      <= s2_wz_in;
         s2_tag_ff.idx <= s2_idx_full[11:0];
         s2_tag_ff.ok  <= (radius_ff != '0) && (strength_ff != '0);
      end
   end

   // Stage 3: distance to the centre on each axis and the bounding-square test.
   logic                     s3_vld_ff;
   rsbw_tag_type             s3_tag_ff;
   logic [15:0]              s3_adx_ff, s3_adz_ff;
   logic signed [DIFF_W-1:0] s3_dx, s3_dz;
   logic [DIFF_W-1:0]        s3_ax, s3_az;
   logic                     s3_inbox;

   always_comb begin
      s3_dx    = DIFF_W'(s2_wx_ff) - DIFF_W'(center_x_ff);
      s3_dz    = DIFF_W'(s2_wz_ff) - DIFF_W'(center_z_ff);
      s3_ax    = s3_dx[DIFF_W-1] ? DIFF_W'(-s3_dx) : DIFF_W'(s3_dx);
      s3_az    = s3_dz[DIFF_W-1] ? DIFF_W'(-s3_dz) : DIFF_W'(s3_dz);
      s3_inbox = (s3_ax <= DIFF_W'(radius_ff)) && (s3_az <= DIFF_W'(radius_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_adx_ff     <= s3_ax[15:0];
         s3_adz_ff     <= s3_az[15:0];
         s3_tag_ff.idx <= s2_tag_ff.idx;
         s3_tag_ff.ok  <= s2_tag_ff.ok && s3_inbox;
      end
   end

   // Stage 4: squares of both distances and of the radius.
   logic         s4_vld_ff;
   rsbw_tag_type s4_tag_ff;
   logic [31:0]  s4_sqx_ff, s4_sqz_ff, s4_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sqx_ff <= s3_adx_ff * s3_adx_ff;
         s4_sqz_ff <= s3_adz_ff * s3_adz_ff;
         s4_r2_ff  <= radius_ff * radius_ff;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   // Stage 5: squared distance and the circle test.
   logic         s5_vld_ff;
   rsbw_tag_type s5_tag_ff;
   logic [31:0]  s5_d2_ff;
   logic [32:0]  s5_d2;

   assign s5_d2 = 33'(s4_sqx_ff) + 33'(s4_sqz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_d2_ff      <= s5_d2[31:0];
         s5_tag_ff.idx <= s4_tag_ff.idx;
         s5_tag_ff.ok  <= s4_tag_ff.ok && (s5_d2 <= 33'(s4_r2_ff));
      end
   end

   // Square-root pipeline: floor(sqrt(d2 * 2^32)), one root bit a stage.
   // The radicand's low 32 bits are zero, so zeros shift in behind d2.
   logic         sq_vld_ff  [SQRT_STEPS];
   rsbw_tag_type sq_tag_ff  [SQRT_STEPS];
   logic [34:0]  sq_rem_ff  [SQRT_STEPS];
   logic [31:0]  sq_root_ff [SQRT_STEPS];
   logic [31:0]  sq_rad_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic         vld_prev;
      rsbw_tag_type tag_prev;
      logic [34:0]  rem_prev;
      logic [31:0]  root_prev;
      logic [31:0]  rad_prev;
      logic [34:0]  rem_try;
      logic [34:0]  trial;
      logic         take;

      if (k == 0) begin : g_first
         assign vld_prev  = s5_vld_ff;
         assign tag_prev  = s5_tag_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = s5_d2_ff;
      end else begin : g_next
         assign vld_prev  = sq_vld_ff[k-1];
         assign tag_prev  = sq_tag_ff[k-1];
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
         assign rad_prev  = sq_rad_ff[k-1];
      end

      always_comb begin
         rem_try = {rem_prev[32:0], rad_prev[31:30]};
         trial   = {1'b0, root_prev, 2'b01};
         take    = (rem_try >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_tag_ff[k]  <= tag_prev;
            sq_rem_ff[k]  <= take ? (rem_try - trial) : rem_try;
            sq_root_ff[k] <= {root_prev[30:0], take};
            sq_rad_ff[k]  <= {rad_prev[29:0], 2'b00};
         end
      end
   end

   // Divider pipeline: u = floor(s / radius), one quotient bit a stage.
   // Inside the circle s <= radius * 2^16, so 17 quotient bits suffice.
   logic         dv_vld_ff [DIV_STEPS];
   rsbw_tag_type dv_tag_ff [DIV_STEPS];
   logic [16:0]  dv_rem_ff [DIV_STEPS];
   logic [16:0]  dv_q_ff   [DIV_STEPS];
   logic [16:0]  dv_s_ff   [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic         vld_prev;
      rsbw_tag_type tag_prev;
      logic [16:0]  rem_prev;
      logic [16:0]  q_prev;
      logic [16:0]  s_prev;
      logic [16:0]  rem_try;
      logic         take;

      if (j == 0) begin : g_first
         assign vld_prev = sq_vld_ff[SQRT_STEPS-1];
         assign tag_prev = sq_tag_ff[SQRT_STEPS-1];
         assign rem_prev = {2'b00, sq_root_ff[SQRT_STEPS-1][31:17]};
         assign q_prev   = '0;
         assign s_prev   = sq_root_ff[SQRT_STEPS-1][16:0];
      end else begin : g_next
         assign vld_prev = dv_vld_ff[j-1];
         assign tag_prev = dv_tag_ff[j-1];
         assign rem_prev = dv_rem_ff[j-1];
         assign q_prev   = dv_q_ff[j-1];
         assign s_prev   = dv_s_ff[j-1];
      end

      always_comb begin
         rem_try = {rem_prev[15:0], s_prev[16]};
         take    = (rem_try >= 17'(radius_ff));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_tag_ff[j] <= tag_prev;
            dv_rem_ff[j] <= take ? (rem_try - 17'(radius_ff)) : rem_try;
            dv_q_ff[j]   <= {q_prev[15:0], take};
            dv_s_ff[j]   <= {s_prev[15:0], 1'b0};
         end
      end
   end

   // Stage 6: u squared and the term 3 - 2u.
   logic         s6_vld_ff;
   rsbw_tag_type s6_tag_ff;
   logic [16:0]  s6_u2_ff;
   logic [17:0]  s6_t_ff;
   logic [16:0]  s6_u;
   logic [33:0]  s6_uu;

   always_comb begin
      s6_u  = dv_q_ff[DIV_STEPS-1];
      s6_uu = 34'(s6_u) * 34'(s6_u);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= dv_vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_tag_ff <= dv_tag_ff[DIV_STEPS-1];
         s6_u2_ff  <= s6_uu[32:16];
         s6_t_ff   <= Q16_THREE - {s6_u, 1'b0};
      end
   end

   // Stage 7: smoothstep value p = u^2 * (3 - 2u).
   logic         s7_vld_ff;
   rsbw_tag_type s7_tag_ff;
   logic [18:0]  s7_p_ff;
   logic [34:0]  s7_prod;

   assign s7_prod = 35'(s6_u2_ff) * 35'(s6_t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_tag_ff <= s6_tag_ff;
         s7_p_ff   <= s7_prod[34:16];
      end
   end

   // Stage 8: falloff 1 - p, scaled by the strength.
   logic         s8_vld_ff;
   rsbw_tag_type s8_tag_ff;
   logic [16:0]  s8_wt_ff;
   logic [16:0]  s8_w;
   logic [32:0]  s8_prod;

   always_comb begin
      s8_w    = (s7_p_ff >= 19'(Q16_ONE)) ? '0 : (Q16_ONE - s7_p_ff[16:0]);
      s8_prod = 33'(s8_w) * 33'(strength_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_tag_ff <= s7_tag_ff;
         s8_wt_ff  <= s8_prod[32:16];
      end
   end

   // Output register: saturate, mask misses and flag hits.
   rsbw_rsp_type out_ff;
   logic [15:0]  out_wt;

   always_comb begin
      if (!s8_tag_ff.ok) begin
         out_wt = '0;
      end else if (s8_wt_ff[16]) begin
         out_wt = '1;
      end else begin
         out_wt = s8_wt_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.hit        <= (out_wt != '0);
         out_ff.cell_index <= s8_tag_ff.idx;
         out_ff.weight     <= out_wt;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // The hit flag agrees with the weight on every response.
   a_hit_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit == (rsp_data.weight != '0)))
      else $error("hit flag disagrees with weight");

   // A disabled brush never reports a hit.
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((radius_ff == '0) || (strength_ff == '0))) |-> !rsp_data.hit)
      else $error("hit reported with the brush disabled");

   // A held response blocks new requests.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while the output is held");

endmodule
